// ===== hdl/mtaw_pkg.sv =====
// ============================================================================
// mtaw_pkg
// Shared types and fixed-point constants for the adaptive multitaper
// weighting core and its long divider.
// ============================================================================
package mtaw_pkg;

    // Long divider sizing: widest dividend, widest divisor, length field.
    localparam int DIV_W     = 66;
    localparam int DIVISOR_W = 52;
    localparam int DIV_LEN_W = 7;

    // Quotient lengths, one per kind of division.
    localparam logic [DIV_LEN_W-1:0] LEN_RATIO = 7'd48;
    localparam logic [DIV_LEN_W-1:0] LEN_NORM  = 7'd49;
    localparam logic [DIV_LEN_W-1:0] LEN_MEAN  = 7'd52;
    localparam logic [DIV_LEN_W-1:0] LEN_RN    = 7'd46;
    localparam logic [DIV_LEN_W-1:0] LEN_DOF   = 7'd66;

    localparam int LANE_SLOTS = 8;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0] Q_MAX     = 18'h20000;
    localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
    localparam logic [12:0] DOF_MAX   = 13'd4096;
    localparam logic [15:0] FAIL_MAX  = 16'hFFFF;
    localparam logic [13:0] TOL_DEN   = 14'd10000;

    // Configuration register indexes and reset values.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPER_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_VARIANCE = 1'b1;
    localparam logic [3:0]  TAPER_COUNT_RESET = 4'd5;
    localparam logic [31:0] NOISE_RESET       = 32'h0001_0000;

    typedef struct packed {
        logic                 start;
        logic [DIV_LEN_W-1:0] len;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/multitaper_adaptive_weighting_core.sv =====
// ============================================================================
// multitaper_adaptive_weighting_core
// Adaptive weighting of taper eigenspectra, one frequency bin at a time.
// ============================================================================
// Eigenvalues and spectrum powers sit in two small synchronous memories; a
// sequencer walks the tapers one at a time through a shared 33x33 multiplier
// and a shared one-bit-per-cycle long divider. Load items and spectrum items
// that do not close a bin are taken without starting the sequencer. The item
// that closes a bin of n tapers holds the input through the start of the bin,
// up to MAX_ITERATIONS adaptive passes, the final weights, the degrees of
// freedom and the n results, and longer while a result item stalls; the long
// divider sets almost all of that time.
// Results leave through an output register.
module multitaper_adaptive_weighting_core #(
    parameter int MAX_TAPERS     = 8,
    parameter int MAX_ITERATIONS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mtaw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [31:0]                           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic [2:0]                            taper_index,
    input  logic [31:0]                           sample_value,
    input  logic                                  last_bin,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            out_taper,
    output logic [16:0]                           taper_weight,
    output logic [31:0]                           adaptive_power,
    output logic [12:0]                           degrees_freedom,
    output logic                                  not_converged,
    output logic [15:0]                           failed_total,
    output logic                                  last_of_run
);
    import mtaw_pkg::*;

    localparam int LANES = (MAX_TAPERS < 8) ? MAX_TAPERS : 8;
    localparam int AW    = $clog2(MAX_TAPERS);
    localparam int IW    = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_INIT_RD, S_INIT_A, S_INIT_B, S_PASS,
        S_W_RD, S_W_BIAS, S_W_EP, S_W_DEN, S_W_DIV, S_W_ER, S_W_Q, S_W_QR, S_W_STORE,
        S_WMAX, S_N_RD, S_N_DIV, S_N_WAIT, S_N_MUL, S_N_ACC,
        S_AX_START, S_AX_WAIT, S_CHK_MUL, S_CHK_CMP,
        S_FIN, S_FIN_AFTER, S_D_RD, S_D_DIV, S_D_WAIT, S_D_SQ, S_D_ERN, S_D_R4, S_D_ACC,
        S_DOF_SQ, S_DOF_DIV, S_DOF_WAIT, S_O_START, S_O_WAIT, S_O_LOAD
    } state_t;

    state_t state_reg;

    // Memories
    logic [16:0] eigen_mem [MAX_TAPERS];
    logic [31:0] spec_mem  [MAX_TAPERS];
    logic [16:0] eig_q;
    logic [31:0] spec_q;

    // Configuration
    logic [3:0]  taper_count_reg;
    logic [31:0] noise_reg;

    // Sequencer state
    logic [2:0]    lane_reg;
    logic [IW-1:0] iter_reg;
    logic          final_reg;
    logic          conv_reg;
    logic          last_reg;
    logic [15:0]   fail_reg;
    logic [31:0]   p_reg;
    logic [31:0]   s0_reg;
    logic [31:0]   bias_reg;
    logic [31:0]   r_reg;
    logic [17:0]   q_reg;
    logic [32:0]   wmax_reg;
    logic [35:0]   wsum_reg;
    logic [31:0]   rmax_reg;
    logic [16:0]   wn_reg;
    logic [51:0]   fn_reg;
    logic [19:0]   fx_reg;
    logic [31:0]   ax_reg;
    logic [14:0]   rn_reg;
    logic [28:0]   rn2_reg;
    logic [32:0]   df_reg;
    logic [59:0]   dfs_reg;
    logic [12:0]   dof_reg;
    logic [16:0]   wt_reg;
    logic [32:0]   wbuf_reg [LANE_SLOTS];
    logic [31:0]   rbuf_reg [LANE_SLOTS];
    logic [65:0]   mul_reg;

    logic          out_valid_reg;
    logic [2:0]    out_taper_reg;
    logic [16:0]   out_weight_reg;
    logic [31:0]   out_power_reg;
    logic [12:0]   out_dof_reg;
    logic          out_nc_reg;
    logic [15:0]   out_fail_reg;
    logic          out_last_reg;

    // Combinational helpers
    logic          in_fire;
    logic          idx_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [2:0]    n_m1;
    logic          lane_last;
    logic [32:0]   mul_a;
    logic [32:0]   mul_b;
    logic [65:0]   mul_prod;
    logic [33:0]   den;
    logic [31:0]   r_next;
    logic [32:0]   w_next;
    logic [31:0]   diff;
    logic [33:0]   tol_rhs;
    logic          out_free;
    div_req_t      div_req;
    div_rsp_t      div_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign idx_ok    = 32'(taper_index) < MAX_TAPERS;
    assign wr_addr   = AW'({{AW{1'b0}}, taper_index});
    assign rd_addr   = AW'({{AW{1'b0}}, lane_reg});
    assign lane_last = (lane_reg == n_m1);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (taper_count_reg < 4'd2)
            n_m1 = 3'd1;
        else if (32'(taper_count_reg) > LANES)
            n_m1 = 3'(LANES - 1);
        else
            n_m1 = 3'(taper_count_reg - 4'd1);
    end

    // Taper stores: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (in_fire && idx_ok)
        begin
            if (!action)
                eigen_mem[wr_addr] <= (sample_value > 32'(ONE_Q16)) ? ONE_Q16
                                                                    : sample_value[16:0];
            else
                spec_mem[wr_addr] <= sample_value;
        end
        eig_q  <= eigen_mem[rd_addr];
        spec_q <= spec_mem[rd_addr];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_W_BIAS:
            begin
                mul_a = 33'(ONE_Q16 - eig_q);
                mul_b = 33'(noise_reg);
            end
            S_W_EP:
            begin
                mul_a = 33'(eig_q);
                mul_b = 33'(p_reg);
            end
            S_W_ER:
            begin
                mul_a = 33'(eig_q);
                mul_b = 33'(r_reg);
            end
            S_W_QR:
            begin
                mul_a = 33'(q_reg);
                mul_b = 33'(r_reg);
            end
            S_N_MUL:
            begin
                mul_a = 33'(wn_reg);
                mul_b = 33'(spec_q);
            end
            S_CHK_MUL:
            begin
                mul_a = 33'(diff);
                mul_b = 33'(TOL_DEN);
            end
            S_D_SQ:
            begin
                mul_a = 33'(rn_reg);
                mul_b = 33'(rn_reg);
            end
            S_D_ERN:
            begin
                mul_a = 33'(eig_q);
                mul_b = 33'(mul_reg[28:0]);
            end
            S_D_R4:
            begin
                mul_a = 33'(rn2_reg);
                mul_b = 33'(rn2_reg);
            end
            S_DOF_SQ:
            begin
                mul_a = df_reg;
                mul_b = df_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = 66'(mul_a) * 66'(mul_b);
    assign den      = 34'(mul_reg[48:16]) + 34'(bias_reg);
    assign r_next   = (div_rsp.quotient[65:32] != '0) ? RATIO_MAX : div_rsp.quotient[31:0];
    assign w_next   = mul_reg[48:16];
    assign diff     = (ax_reg > p_reg) ? (ax_reg - p_reg) : (p_reg - ax_reg);
    assign tol_rhs  = {2'b00, ax_reg} + {1'b0, ax_reg, 1'b0};

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_W_DEN:
            begin
                div_req.start    = (den != '0);
                div_req.len      = LEN_RATIO;
                div_req.dividend = DIV_W'({p_reg, 16'h0000});
                div_req.divisor  = DIVISOR_W'(den);
            end
            S_N_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.len      = LEN_NORM;
                div_req.dividend = DIV_W'({wbuf_reg[lane_reg], 16'h0000});
                div_req.divisor  = DIVISOR_W'(wmax_reg);
            end
            S_AX_START:
            begin
                div_req.start    = 1'b1;
                div_req.len      = LEN_MEAN;
                div_req.dividend = DIV_W'(fn_reg);
                div_req.divisor  = DIVISOR_W'(fx_reg);
            end
            S_D_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.len      = LEN_RN;
                div_req.dividend = DIV_W'({rbuf_reg[lane_reg], 14'h0000});
                div_req.divisor  = DIVISOR_W'(rmax_reg);
            end
            S_DOF_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.len      = LEN_DOF;
                div_req.dividend = mul_reg;
                div_req.divisor  = DIVISOR_W'(dfs_reg[59:9]);
            end
            S_O_START:
            begin
                div_req.start    = (wsum_reg != '0);
                div_req.len      = LEN_NORM;
                div_req.dividend = DIV_W'({wbuf_reg[lane_reg], 16'h0000});
                div_req.divisor  = DIVISOR_W'(wsum_reg);
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    mtaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            taper_count_reg <= TAPER_COUNT_RESET;
            noise_reg       <= NOISE_RESET;
            lane_reg        <= '0;
            iter_reg        <= '0;
            final_reg       <= 1'b0;
            conv_reg        <= 1'b0;
            last_reg        <= 1'b0;
            fail_reg        <= '0;
            p_reg           <= '0;
            s0_reg          <= '0;
            bias_reg        <= '0;
            r_reg           <= '0;
            q_reg           <= '0;
            wmax_reg        <= '0;
            wsum_reg        <= '0;
            rmax_reg        <= '0;
            wn_reg          <= '0;
            fn_reg          <= '0;
            fx_reg          <= '0;
            ax_reg          <= '0;
            rn_reg          <= '0;
            rn2_reg         <= '0;
            df_reg          <= '0;
            dfs_reg         <= '0;
            dof_reg         <= '0;
            wt_reg          <= '0;
            mul_reg         <= '0;
            for (int i = 0; i < LANE_SLOTS; i++)
            begin
                wbuf_reg[i] <= '0;
                rbuf_reg[i] <= '0;
            end
            out_valid_reg   <= 1'b0;
            out_taper_reg   <= '0;
            out_weight_reg  <= '0;
            out_power_reg   <= '0;
            out_dof_reg     <= '0;
            out_nc_reg      <= 1'b0;
            out_fail_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            mul_reg <= mul_prod;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TAPER_COUNT:    taper_count_reg <= cfg_data[3:0];
                    CFG_NOISE_VARIANCE: noise_reg       <= cfg_data;
                    default:            ;
                endcase
            end

            // While loading, the output register is refilled below instead.
            if (out_valid_reg && out_ready && state_reg != S_O_LOAD)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && idx_ok && action && taper_index == n_m1)
                    begin
                        last_reg  <= last_bin;
                        lane_reg  <= 3'd0;
                        state_reg <= S_INIT_RD;
                    end
                end
                S_INIT_RD:
                begin
                    lane_reg  <= 3'd1;
                    state_reg <= S_INIT_A;
                end
                S_INIT_A:
                begin
                    s0_reg    <= spec_q;
                    state_reg <= S_INIT_B;
                end
                S_INIT_B:
                begin
                    p_reg     <= 32'((33'(s0_reg) + 33'(spec_q)) >> 1);
                    iter_reg  <= '0;
                    conv_reg  <= 1'b0;
                    state_reg <= S_PASS;
                end
                S_PASS:
                begin
                    if (p_reg == '0)
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        lane_reg  <= 3'd0;
                        wmax_reg  <= '0;
                        final_reg <= 1'b0;
                        state_reg <= S_W_RD;
                    end
                end
                // Per-taper weight: bias, denominator, ratio, weight.
                S_W_RD:    state_reg <= S_W_BIAS;
                S_W_BIAS:  state_reg <= S_W_EP;
                S_W_EP:
                begin
                    bias_reg  <= mul_reg[47:16];
                    state_reg <= S_W_DEN;
                end
                S_W_DEN:
                begin
                    if (den == '0)
                    begin
                        r_reg     <= (p_reg != '0) ? RATIO_MAX : '0;
                        state_reg <= S_W_ER;
                    end
                    else
                        state_reg <= S_W_DIV;
                end
                S_W_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg     <= r_next;
                        state_reg <= S_W_ER;
                    end
                end
                S_W_ER:    state_reg <= S_W_Q;
                S_W_Q:
                begin
                    q_reg     <= (mul_reg[65:16] > 50'(Q_MAX)) ? Q_MAX : mul_reg[33:16];
                    state_reg <= S_W_QR;
                end
                S_W_QR:    state_reg <= S_W_STORE;
                S_W_STORE:
                begin
                    wbuf_reg[lane_reg] <= w_next;
                    rbuf_reg[lane_reg] <= r_reg;
                    if (w_next > wmax_reg)
                        wmax_reg <= w_next;
                    wsum_reg <= wsum_reg + 36'(w_next);
                    if (r_reg > rmax_reg)
                        rmax_reg <= r_reg;
                    if (lane_last)
                        state_reg <= final_reg ? S_FIN_AFTER : S_WMAX;
                    else
                    begin
                        lane_reg  <= lane_reg + 3'd1;
                        state_reg <= S_W_RD;
                    end
                end
                S_WMAX:
                begin
                    if (wmax_reg == '0)
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        lane_reg  <= 3'd0;
                        fn_reg    <= '0;
                        fx_reg    <= '0;
                        state_reg <= S_N_RD;
                    end
                end
                // Weighted mean of the spectrum with peak-normalized weights.
                S_N_RD:    state_reg <= S_N_DIV;
                S_N_DIV:   state_reg <= S_N_WAIT;
                S_N_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        wn_reg    <= div_rsp.quotient[16:0];
                        state_reg <= S_N_MUL;
                    end
                end
                S_N_MUL:   state_reg <= S_N_ACC;
                S_N_ACC:
                begin
                    fn_reg <= fn_reg + 52'(mul_reg[48:0]);
                    fx_reg <= fx_reg + 20'(wn_reg);
                    if (lane_last)
                        state_reg <= S_AX_START;
                    else
                    begin
                        lane_reg  <= lane_reg + 3'd1;
                        state_reg <= S_N_RD;
                    end
                end
                S_AX_START: state_reg <= S_AX_WAIT;
                S_AX_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ax_reg    <= div_rsp.quotient[31:0];
                        state_reg <= S_CHK_MUL;
                    end
                end
                S_CHK_MUL: state_reg <= S_CHK_CMP;
                S_CHK_CMP:
                begin
                    p_reg    <= ax_reg;
                    iter_reg <= iter_reg + 1'b1;
                    if (mul_reg < 66'(tol_rhs))
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else if (iter_reg == IW'(MAX_ITERATIONS - 1))
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_PASS;
                end
                S_FIN:
                begin
                    if (!conv_reg && fail_reg != FAIL_MAX)
                        fail_reg <= fail_reg + 16'd1;
                    final_reg <= 1'b1;
                    lane_reg  <= 3'd0;
                    wmax_reg  <= '0;
                    wsum_reg  <= '0;
                    rmax_reg  <= '0;
                    state_reg <= S_W_RD;
                end
                S_FIN_AFTER:
                begin
                    lane_reg <= 3'd0;
                    df_reg   <= '0;
                    dfs_reg  <= '0;
                    if (rmax_reg == '0)
                    begin
                        dof_reg   <= '0;
                        state_reg <= S_O_START;
                    end
                    else
                        state_reg <= S_D_RD;
                end
                // Degrees of freedom from the ratios scaled to their peak.
                S_D_RD:    state_reg <= S_D_DIV;
                S_D_DIV:   state_reg <= S_D_WAIT;
                S_D_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        rn_reg    <= div_rsp.quotient[14:0];
                        state_reg <= S_D_SQ;
                    end
                end
                S_D_SQ:    state_reg <= S_D_ERN;
                S_D_ERN:
                begin
                    rn2_reg   <= mul_reg[28:0];
                    state_reg <= S_D_R4;
                end
                S_D_R4:
                begin
                    df_reg    <= df_reg + 33'(mul_reg[45:16]);
                    state_reg <= S_D_ACC;
                end
                S_D_ACC:
                begin
                    dfs_reg <= dfs_reg + 60'(mul_reg[56:0]);
                    if (lane_last)
                        state_reg <= S_DOF_SQ;
                    else
                    begin
                        lane_reg  <= lane_reg + 3'd1;
                        state_reg <= S_D_RD;
                    end
                end
                S_DOF_SQ:  state_reg <= S_DOF_DIV;
                S_DOF_DIV: state_reg <= S_DOF_WAIT;
                S_DOF_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        dof_reg   <= (div_rsp.quotient > 66'(DOF_MAX)) ? DOF_MAX
                                                                       : div_rsp.quotient[12:0];
                        lane_reg  <= 3'd0;
                        state_reg <= S_O_START;
                    end
                end
                // One result item per taper.
                S_O_START:
                begin
                    if (wsum_reg == '0)
                    begin
                        wt_reg    <= '0;
                        state_reg <= S_O_LOAD;
                    end
                    else
                        state_reg <= S_O_WAIT;
                end
                S_O_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        wt_reg    <= (div_rsp.quotient > 66'(ONE_Q16)) ? ONE_Q16
                                                                       : div_rsp.quotient[16:0];
                        state_reg <= S_O_LOAD;
                    end
                end
                S_O_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_taper_reg  <= lane_reg;
                        out_weight_reg <= wt_reg;
                        out_power_reg  <= p_reg;
                        out_dof_reg    <= dof_reg;
                        out_nc_reg     <= !conv_reg;
                        out_fail_reg   <= fail_reg;
                        out_last_reg   <= lane_last;
                        if (lane_last)
                        begin
                            if (last_reg)
                                fail_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            lane_reg  <= lane_reg + 3'd1;
                            state_reg <= S_O_START;
                        end
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_taper       = out_taper_reg;
    assign taper_weight    = out_weight_reg;
    assign adaptive_power  = out_power_reg;
    assign degrees_freedom = out_dof_reg;
    assign not_converged   = out_nc_reg;
    assign failed_total    = out_fail_reg;
    assign last_of_run     = out_last_reg;

endmodule

// ===== hdl/mtaw_div.sv =====
// ============================================================================
// mtaw_div
// Restoring long divider, one quotient bit per cycle. The dividend is
// left-aligned so that only the requested number of quotient bits is run.
// ============================================================================
module mtaw_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mtaw_pkg::div_req_t req,
    output mtaw_pkg::div_rsp_t rsp
);
    import mtaw_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_LEN_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIV_W-1:0]     quo_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;

    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.len;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend << (7'(DIV_W) - req.len);
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/mtaw_checker.sv =====
// ============================================================================
// mtaw_checker
// Port-level checks on the result channel of the weighting core.
// ============================================================================
module mtaw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_taper,
    input logic [16:0] taper_weight,
    input logic [12:0] degrees_freedom,
    input logic        not_converged,
    input logic [15:0] failed_total,
    input logic        last_of_run
);

    // A stalled result item keeps its taper and weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_taper) && $stable(taper_weight))
        else $error("result item changed while stalled");

    // Weights never exceed one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> taper_weight <= 17'h10000)
        else $error("taper weight above one");

    // Degrees of freedom are clamped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> degrees_freedom <= 13'd4096)
        else $error("degrees of freedom above limit");

    // A failed bin is already counted in the total it reports.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_converged |-> failed_total != 16'd0)
        else $error("failed bin not counted");

    // Taper seven can only be the last taper of a bin.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_taper == 3'd7 |-> last_of_run)
        else $error("taper seven without end of bin");

endmodule

bind multitaper_adaptive_weighting_core mtaw_checker u_mtaw_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the adaptive multitaper weighting core. Eigenvalue
// and spectrum items are sent with random gaps under several register
// settings; a scoreboard predicts the per-taper weight results of every
// closed bin and compares them in order with what the core emits.
// ============================================================================
module tb;
    import mtaw_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 3000;
    localparam bit ACT_EIGEN      = 1'b0;
    localparam bit ACT_SPECTRUM   = 1'b1;

    typedef struct {
        bit [2:0]  taper;
        bit [16:0] weight;
        bit [31:0] power;
        bit [12:0] dof;
        bit        not_conv;
        bit [15:0] failed;
        bit        last;
    } weight_result_t;

    class weight_scoreboard;
        longint unsigned eigen[8];
        longint unsigned spectrum[8];
        longint unsigned ratio[8];
        longint unsigned weight[8];
        int unsigned     fail_cnt;
        bit [3:0]        tapers;
        bit [31:0]       noise;
        weight_result_t  pending_q[$];
        int              errors;

        function new();
            fail_cnt = 0;
            tapers   = TAPER_COUNT_RESET;
            noise    = NOISE_RESET;
            errors   = 0;
        endfunction

        function int lanes();
            if (tapers < 2) return 2;
            if (tapers > 8) return 8;
            return tapers;
        endfunction

        function void set_reg(bit [CFG_INDEX_W-1:0] idx, bit [31:0] val);
            if (idx == CFG_TAPER_COUNT) tapers = val[3:0];
            else noise = val;
        endfunction

        function void compute_weights(longint unsigned p, int n);
            longint unsigned bias, den, q;
            for (int i = 0; i < n; i++) begin
                bias = ((64'd65536 - eigen[i]) * noise) >> 16;
                den  = ((eigen[i] * p) >> 16) + bias;
                if (den == 0) ratio[i] = (p != 0) ? 64'hFFFF_FFFF : 0;
                else begin
                    ratio[i] = (p << 16) / den;
                    if (ratio[i] > 64'hFFFF_FFFF) ratio[i] = 64'hFFFF_FFFF;
                end
                q = (eigen[i] * ratio[i]) >> 16;
                if (q > 64'd131072) q = 64'd131072;
                weight[i] = (q * ratio[i]) >> 16;
            end
        endfunction

        function void note_item(bit act, bit [2:0] idx, bit [31:0] val, bit last_bin);
            longint unsigned p, wmax, wsum, rmax, df, dfs, dof, fn, fx, ax, d, wn, rn2, wt;
            int n;
            bit conv;
            weight_result_t res;
            if (act == ACT_EIGEN) begin
                eigen[idx] = (val > 32'd65536) ? 64'd65536 : val;
                return;
            end
            spectrum[idx] = val;
            n = lanes();
            if (idx != n - 1) return;
            conv = 0;
            p = (spectrum[0] + spectrum[1]) >> 1;
            for (int k = 0; k < 20; k++) begin
                if (p == 0) begin conv = 1; break; end
                compute_weights(p, n);
                wmax = 0;
                for (int i = 0; i < n; i++) if (weight[i] > wmax) wmax = weight[i];
                if (wmax == 0) begin conv = 1; break; end
                fn = 0;
                fx = 0;
                for (int i = 0; i < n; i++) begin
                    wn = (weight[i] << 16) / wmax;
                    fn += wn * spectrum[i];
                    fx += wn;
                end
                ax = fn / fx;
                d  = (ax > p) ? ax - p : p - ax;
                p  = ax;
                if (d * 10000 < 3 * ax) begin conv = 1; break; end
            end
            if (!conv && fail_cnt < 65535) fail_cnt++;
            compute_weights(p, n);
            wsum = 0;
            rmax = 0;
            for (int i = 0; i < n; i++) begin
                wsum += weight[i];
                if (ratio[i] > rmax) rmax = ratio[i];
            end
            dof = 0;
            if (rmax != 0) begin
                df  = 0;
                dfs = 0;
                for (int i = 0; i < n; i++) begin
                    rn2 = (ratio[i] * 64'd16384) / rmax;
                    rn2 = rn2 * rn2;
                    df  += (eigen[i] * rn2) >> 16;
                    dfs += rn2 * rn2;
                end
                dof = (df * df) / (dfs >> 9);
                if (dof > 4096) dof = 4096;
            end
            for (int i = 0; i < n; i++) begin
                wt = 0;
                if (wsum != 0) begin
                    wt = (weight[i] << 16) / wsum;
                    if (wt > 65536) wt = 65536;
                end
                res.taper    = i;
                res.weight   = wt;
                res.power    = p;
                res.dof      = dof;
                res.not_conv = !conv;
                res.failed   = fail_cnt;
                res.last     = (i == n - 1);
                pending_q.push_back(res);
            end
            if (last_bin) fail_cnt = 0;
        endfunction

        function void compare(string name, longint unsigned exp, longint unsigned act);
            if (exp != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(weight_result_t got);
            weight_result_t exp;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual taper %0d",
                         $time, got.taper);
                return;
            end
            exp = pending_q.pop_front();
            compare("out_taper", exp.taper, got.taper);
            compare("taper_weight", exp.weight, got.weight);
            compare("adaptive_power", exp.power, got.power);
            compare("degrees_freedom", exp.dof, got.dof);
            compare("not_converged", exp.not_conv, got.not_conv);
            compare("failed_total", exp.failed, got.failed);
            compare("last_of_run", exp.last, got.last);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_TAPER_COUNT;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        action = 0;
    logic [2:0]  taper_index = 0;
    logic [31:0] sample_value = 0;
    logic        last_bin = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [2:0]  out_taper;
    logic [16:0] taper_weight;
    logic [31:0] adaptive_power;
    logic [12:0] degrees_freedom;
    logic        not_converged;
    logic [15:0] failed_total;
    logic        last_of_run;

    weight_scoreboard sb = new();
    int idle_cycles = 0;
    bit burst_tx = 0;
    bit burst_rx = 0;

    multitaper_adaptive_weighting_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .taper_index(taper_index),
        .sample_value(sample_value), .last_bin(last_bin),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_taper(out_taper), .taper_weight(taper_weight),
        .adaptive_power(adaptive_power), .degrees_freedom(degrees_freedom),
        .not_converged(not_converged), .failed_total(failed_total),
        .last_of_run(last_of_run)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        if (burst || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic bit [31:0] rand_power();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            3: return 32'h0001_0000 + $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] rand_eigen();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'h0001_0000;
            2: return $urandom;
            3: return $urandom_range(0, 65535);
            default: return 65536 - $urandom_range(0, 2000);
        endcase
    endfunction

    task automatic write_reg(bit [CFG_INDEX_W-1:0] idx, bit [31:0] val);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_item(bit act, bit [2:0] idx, bit [31:0] val, bit lb);
        int gap;
        gap = draw_gap(burst_tx);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1;
        action       <= act;
        taper_index  <= idx;
        sample_value <= val;
        last_bin     <= lb;
        do @(posedge clk); while (!in_ready);
        sb.note_item(act, idx, val, lb);
    endtask

    // Phase boundary: stop offering items and let the core drain completely.
    task automatic settle();
        @(posedge clk);
        in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_bin(bit lb);
        int n;
        n = sb.lanes();
        for (int t = 0; t < n; t++) send_item(ACT_SPECTRUM, t, rand_power(), lb);
    endtask

    task automatic random_phase(bit [3:0] tc, bit [31:0] nv, int items);
        int sent;
        settle();
        write_reg(CFG_TAPER_COUNT, tc);
        write_reg(CFG_NOISE_VARIANCE, nv);
        sent = 0;
        while (sent < items) begin
            if (sent % 30 == 0) burst_tx = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    send_item($urandom_range(0, 1), $urandom_range(0, 7), $urandom,
                              $urandom_range(0, 1));
                    sent++;
                end
                1, 2: begin
                    send_item(ACT_EIGEN, $urandom_range(0, 7), rand_eigen(),
                              $urandom_range(0, 1));
                    sent++;
                end
                default: begin
                    send_bin($urandom_range(0, 3) == 0);
                    sent += sb.lanes();
                end
            endcase
        end
    endtask

    // Receiver: random stalls, bursts without stalls, and one long hold-off.
    initial
    begin
        int gap;
        int count;
        weight_result_t got;
        count = 0;
        @(posedge rst_n);
        forever begin
            if (count % 32 == 0) burst_rx = ($urandom_range(0, 2) == 0);
            gap = (count == 30) ? HOLD_CYCLES : draw_gap(burst_rx);
            if (gap > 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            got.taper    = out_taper;
            got.weight   = taper_weight;
            got.power    = adaptive_power;
            got.dof      = degrees_freedom;
            got.not_conv = not_converged;
            got.failed   = failed_total;
            got.last     = last_of_run;
            sb.check_result(got);
            count++;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Full table fill with eight tapers, including an eigenvalue above one.
        write_reg(CFG_TAPER_COUNT, 8);
        send_item(ACT_EIGEN, 0, 32'h0001_0000, 0);
        send_item(ACT_EIGEN, 1, 32'hFFFF_FFFF, 0);
        send_item(ACT_EIGEN, 2, 32'd70000, 0);
        send_item(ACT_EIGEN, 3, 32'd65000, 0);
        send_item(ACT_EIGEN, 4, 32'd60000, 0);
        send_item(ACT_EIGEN, 5, 32'd40000, 0);
        send_item(ACT_EIGEN, 6, 32'd10000, 0);
        send_item(ACT_EIGEN, 7, 32'd0, 0);
        send_item(ACT_SPECTRUM, 0, 32'hFFFF_FFFF, 0);
        send_item(ACT_SPECTRUM, 1, 32'hFFFF_FFFF, 0);
        send_item(ACT_SPECTRUM, 2, 32'd0, 0);
        send_item(ACT_SPECTRUM, 3, 32'h0001_0000, 0);
        send_item(ACT_SPECTRUM, 4, 32'h0000_0001, 0);
        send_item(ACT_SPECTRUM, 5, 32'h8000_0000, 0);
        send_item(ACT_SPECTRUM, 6, 32'h0002_0000, 0);
        send_item(ACT_SPECTRUM, 7, 32'h0001_8000, 1);

        // Two tapers, no noise: zero estimate, an index beyond the count,
        // then zero eigenvalues so every denominator and weight is zero.
        settle();
        write_reg(CFG_TAPER_COUNT, 2);
        write_reg(CFG_NOISE_VARIANCE, 0);
        send_item(ACT_SPECTRUM, 0, 32'd0, 0);
        send_item(ACT_SPECTRUM, 1, 32'd0, 1);
        send_item(ACT_SPECTRUM, 5, 32'h1234_5678, 0);
        send_item(ACT_EIGEN, 0, 32'd0, 0);
        send_item(ACT_EIGEN, 1, 32'd0, 0);
        send_item(ACT_SPECTRUM, 0, 32'h0003_0000, 0);
        send_item(ACT_SPECTRUM, 1, 32'h0005_0000, 1);
        send_item(ACT_EIGEN, 0, 32'd65536, 0);
        send_item(ACT_EIGEN, 1, 32'd64000, 0);

        random_phase(4'd15, 32'hFFFF_FFFF, 45);
        random_phase(4'd0, $urandom, 45);
        random_phase(4'd5, NOISE_RESET, 50);
        random_phase(4'd8, 32'd1, 50);
        random_phase(4'd3, $urandom_range(0, 32'h0010_0000), 45);
        random_phase(4'd7, 32'd0, 45);

        settle();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/mtaw_pkg.sv
hdl/mtaw_div.sv
hdl/multitaper_adaptive_weighting_core.sv
hdl/mtaw_checker.sv
bench/tb.sv
